// ----- hdl/abht_pkg.sv -----
// Shared types and constants for the aircraft blip table with touch hit test.
// Used by abht_div, abht_scan and aircraft_blip_table_hit_test; depends on nothing.
package abht_pkg;

  // Field widths
  localparam int LAT_W      = 21;
  localparam int LON_W      = 22;
  localparam int MAP_W      = 10;
  localparam int DIST_W     = 20;
  localparam int ALT_W      = 16;
  localparam int LOWALT_W   = 15;
  localparam int TAG_W      = 8;
  localparam int TOUCH_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // Divider operand widths: offset numerator / range fit 22 bits unsigned
  localparam int NUM_W  = 22;
  localparam int PROD_W = NUM_W + MAP_W;

  // Register reset values
  localparam logic signed [LAT_W-1:0] LAT_SOUTH_RST = -21'sd410000;
  localparam logic signed [LAT_W-1:0] LAT_NORTH_RST = -21'sd330000;
  localparam logic signed [LON_W-1:0] LON_WEST_RST  = -22'sd635000;
  localparam logic signed [LON_W-1:0] LON_EAST_RST  = -22'sd565000;
  localparam logic [MAP_W-1:0]        MAP_WIDTH_RST  = 10'd312;
  localparam logic [MAP_W-1:0]        MAP_HEIGHT_RST = 10'd200;
  localparam logic [DIST_W-1:0]       NEAR_DIST_RST  = 20'd10000;
  localparam logic [LOWALT_W-1:0]     LOW_ALT_RST    = 15'd3000;

  // Commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_TOUCH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Add status codes
  localparam logic [1:0] ST_STORED   = 2'd0;
  localparam logic [1:0] ST_GROUNDED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Colour classes
  localparam logic [1:0] CLS_NORMAL = 2'd0;
  localparam logic [1:0] CLS_NEAR   = 2'd1;
  localparam logic [1:0] CLS_LOW    = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_SOUTH  = 3'd0,
    REG_LAT_NORTH  = 3'd1,
    REG_LON_WEST   = 3'd2,
    REG_LON_EAST   = 3'd3,
    REG_MAP_WIDTH  = 3'd4,
    REG_MAP_HEIGHT = 3'd5,
    REG_NEAR_DIST  = 3'd6,
    REG_LOW_ALT    = 3'd7
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIVX,
    S_STARTY,
    S_DIVY,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

  // Scan unit control
  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

endpackage

// ----- hdl/aircraft_blip_table_hit_test.sv -----
// Aircraft blip table with touch hit test.
// A storing add runs two divider passes, x then y, of 10 steps each; other adds, clear and
// no-op skip the divider; touch reads one blip per cycle from the table memory, and skips
// the scan on an empty table.
// One request at a time: in_ready returns the cycle after the result loads.
// Reset: blip count zero, registers to defaults, table memory not cleared. Uses abht_pkg/div/scan.
module aircraft_blip_table_hit_test #(
  parameter int MAX_BLIPS = 80,
  parameter int HIT_PAD   = 12,
  localparam int SLOT_W   = (MAX_BLIPS > 1) ? $clog2(MAX_BLIPS) : 1,
  localparam int CNT_W    = $clog2(MAX_BLIPS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [abht_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [abht_pkg::CFG_DATA_W-1:0]       cfg_data,
  // request
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            command,
  input  logic signed [abht_pkg::LAT_W-1:0]     lat_pos,
  input  logic signed [abht_pkg::LON_W-1:0]     lon_pos,
  input  logic                                  grounded,
  input  logic [abht_pkg::DIST_W-1:0]           dist_home_m,
  input  logic signed [abht_pkg::ALT_W-1:0]     baro_alt_m,
  input  logic [abht_pkg::TAG_W-1:0]            aircraft_tag,
  input  logic signed [abht_pkg::TOUCH_W-1:0]   touch_x,
  input  logic signed [abht_pkg::TOUCH_W-1:0]   touch_y,
  // result
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            add_status,
  output logic [abht_pkg::MAP_W-1:0]            pixel_x,
  output logic [abht_pkg::MAP_W-1:0]            pixel_y,
  output logic [1:0]                            colour_class,
  output logic [SLOT_W-1:0]                     stored_slot,
  output logic                                  hit_found,
  output logic [SLOT_W-1:0]                     hit_slot,
  output logic [abht_pkg::TAG_W-1:0]            hit_tag,
  output logic [CNT_W-1:0]                      blip_total
);

  localparam int MEM_W = 2 * abht_pkg::MAP_W + abht_pkg::TAG_W;

  // Configuration registers
  logic signed [abht_pkg::LAT_W-1:0] lat_south, lat_north;
  logic signed [abht_pkg::LON_W-1:0] lon_west, lon_east;
  logic [abht_pkg::MAP_W-1:0]        map_width, map_height;
  logic [abht_pkg::DIST_W-1:0]       near_dist_m;
  logic [abht_pkg::LOWALT_W-1:0]     low_alt_m;

  // Latched request
  abht_pkg::cmd_t                    item_cmd;
  logic signed [abht_pkg::LAT_W-1:0] item_lat;
  logic signed [abht_pkg::LON_W-1:0] item_lon;
  logic                              item_ground;
  logic [abht_pkg::DIST_W-1:0]       item_dist;
  logic signed [abht_pkg::ALT_W-1:0] item_alt;
  logic [abht_pkg::TAG_W-1:0]        item_tag;
  logic signed [abht_pkg::TOUCH_W-1:0] item_tx, item_ty;

  // Sequencer and table state
  abht_pkg::state_t state, state_next;
  logic [CNT_W-1:0]  blip_count;
  logic [SLOT_W-1:0] rd_idx, scan_idx;
  logic              scan_valid;
  logic [MEM_W-1:0]  blip_mem [MAX_BLIPS];
  logic [MEM_W-1:0]  rd_data;

  // Working result
  logic [1:0]                 res_status, res_cls;
  logic [abht_pkg::MAP_W-1:0] res_px, res_py;
  logic [SLOT_W-1:0]          res_slot;

  // Strobes
  logic accept, div_start, mem_we, rd_en, load_out, last_issue;

  // Evaluation of an add
  logic                              in_bounds;
  logic [1:0]                        add_code;
  logic [1:0]                        cls_code;
  logic signed [abht_pkg::LON_W:0]   lon_off, lon_rng;
  logic signed [abht_pkg::LAT_W:0]   lat_off, lat_rng;
  logic [abht_pkg::PROD_W-1:0]       div_dividend;
  logic [abht_pkg::NUM_W-1:0]        div_divisor;
  logic                              div_done;
  logic [abht_pkg::MAP_W-1:0]        div_q;

  abht_pkg::scan_ctl_t        scan_ctl;
  logic                       scan_found;
  logic [SLOT_W-1:0]          scan_slot;
  logic [abht_pkg::TAG_W-1:0] scan_tag;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_south   <= abht_pkg::LAT_SOUTH_RST;
      lat_north   <= abht_pkg::LAT_NORTH_RST;
      lon_west    <= abht_pkg::LON_WEST_RST;
      lon_east    <= abht_pkg::LON_EAST_RST;
      map_width   <= abht_pkg::MAP_WIDTH_RST;
      map_height  <= abht_pkg::MAP_HEIGHT_RST;
      near_dist_m <= abht_pkg::NEAR_DIST_RST;
      low_alt_m   <= abht_pkg::LOW_ALT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (abht_pkg::cfg_reg_t'(cfg_index))
        abht_pkg::REG_LAT_SOUTH:  lat_south   <= cfg_data[abht_pkg::LAT_W-1:0];
        abht_pkg::REG_LAT_NORTH:  lat_north   <= cfg_data[abht_pkg::LAT_W-1:0];
        abht_pkg::REG_LON_WEST:   lon_west    <= cfg_data[abht_pkg::LON_W-1:0];
        abht_pkg::REG_LON_EAST:   lon_east    <= cfg_data[abht_pkg::LON_W-1:0];
        abht_pkg::REG_MAP_WIDTH:  map_width   <= cfg_data[abht_pkg::MAP_W-1:0];
        abht_pkg::REG_MAP_HEIGHT: map_height  <= cfg_data[abht_pkg::MAP_W-1:0];
        abht_pkg::REG_NEAR_DIST:  near_dist_m <= cfg_data[abht_pkg::DIST_W-1:0];
        abht_pkg::REG_LOW_ALT:    low_alt_m   <= cfg_data[abht_pkg::LOWALT_W-1:0];
        default: ;
      endcase
    end
  end

  // Add checks, class and divider operands
  always_comb begin
    in_bounds = (item_lat >= lat_south) && (item_lat <= lat_north) &&
                (item_lon >= lon_west) && (item_lon <= lon_east);
    if (item_ground) begin
      add_code = abht_pkg::ST_GROUNDED;
    end else if (!in_bounds) begin
      add_code = abht_pkg::ST_OUTSIDE;
    end else if (blip_count >= CNT_W'(MAX_BLIPS)) begin
      add_code = abht_pkg::ST_FULL;
    end else begin
      add_code = abht_pkg::ST_STORED;
    end
    if (item_dist <= near_dist_m) begin
      cls_code = abht_pkg::CLS_NEAR;
    end else if ($signed({item_alt[abht_pkg::ALT_W-1], item_alt}) <=
                 $signed({2'b00, low_alt_m})) begin
      cls_code = abht_pkg::CLS_LOW;
    end else begin
      cls_code = abht_pkg::CLS_NORMAL;
    end
    lon_off = {item_lon[abht_pkg::LON_W-1], item_lon} - {lon_west[abht_pkg::LON_W-1], lon_west};
    lon_rng = {lon_east[abht_pkg::LON_W-1], lon_east} - {lon_west[abht_pkg::LON_W-1], lon_west};
    lat_off = {lat_north[abht_pkg::LAT_W-1], lat_north} - {item_lat[abht_pkg::LAT_W-1], item_lat};
    lat_rng = {lat_north[abht_pkg::LAT_W-1], lat_north} -
              {lat_south[abht_pkg::LAT_W-1], lat_south};
    // x operands while evaluating, y operands afterwards
    if (state == abht_pkg::S_EVAL) begin
      div_dividend = abht_pkg::PROD_W'(lon_off[abht_pkg::NUM_W-1:0]) *
                     abht_pkg::PROD_W'(map_width);
      div_divisor  = lon_rng[abht_pkg::NUM_W-1:0];
    end else begin
      div_dividend = abht_pkg::PROD_W'(lat_off[abht_pkg::NUM_W-1:0]) *
                     abht_pkg::PROD_W'(map_height);
      div_divisor  = lat_rng[abht_pkg::NUM_W-1:0];
    end
  end

  assign last_issue = ((CNT_W'(rd_idx) + 1'b1) == blip_count);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      abht_pkg::S_IDLE: begin
        if (accept) state_next = abht_pkg::S_EVAL;
      end
      abht_pkg::S_EVAL: begin
        case (item_cmd)
          abht_pkg::CMD_ADD: begin
            state_next = (add_code == abht_pkg::ST_STORED) ? abht_pkg::S_DIVX : abht_pkg::S_DONE;
          end
          abht_pkg::CMD_TOUCH: begin
            state_next = (blip_count == '0) ? abht_pkg::S_DONE : abht_pkg::S_SCAN;
          end
          default: state_next = abht_pkg::S_DONE;
        endcase
      end
      abht_pkg::S_DIVX: begin
        if (div_done) state_next = abht_pkg::S_STARTY;
      end
      abht_pkg::S_STARTY: state_next = abht_pkg::S_DIVY;
      abht_pkg::S_DIVY: begin
        if (div_done) state_next = abht_pkg::S_DONE;
      end
      abht_pkg::S_SCAN: begin
        if (last_issue) state_next = abht_pkg::S_TAIL;
      end
      abht_pkg::S_TAIL: state_next = abht_pkg::S_DONE;
      abht_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = abht_pkg::S_IDLE;
      end
      default: state_next = abht_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    case (state)
      abht_pkg::S_IDLE:   in_ready  = 1'b1;
      abht_pkg::S_EVAL:   div_start = (item_cmd == abht_pkg::CMD_ADD) &&
                                      (add_code == abht_pkg::ST_STORED);
      abht_pkg::S_STARTY: div_start = 1'b1;
      abht_pkg::S_DIVY:   mem_we    = div_done;
      abht_pkg::S_SCAN:   rd_en     = 1'b1;
      abht_pkg::S_DONE:   load_out  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abht_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd    <= abht_pkg::cmd_t'(command);
      item_lat    <= lat_pos;
      item_lon    <= lon_pos;
      item_ground <= grounded;
      item_dist   <= dist_home_m;
      item_alt    <= baro_alt_m;
      item_tag    <= aircraft_tag;
      item_tx     <= touch_x;
      item_ty     <= touch_y;
    end
  end

  // Blip count
  always_ff @(posedge clk) begin
    if (rst) begin
      blip_count <= '0;
    end else if (state == abht_pkg::S_EVAL && item_cmd == abht_pkg::CMD_CLEAR) begin
      blip_count <= '0;
    end else if (mem_we) begin
      blip_count <= blip_count + 1'b1;
    end
  end

  // Working result fields
  always_ff @(posedge clk) begin
    if (state == abht_pkg::S_EVAL) begin
      res_px <= '0;
      res_py <= '0;
      if (item_cmd == abht_pkg::CMD_ADD) begin
        res_status <= add_code;
      end else begin
        res_status <= abht_pkg::ST_STORED;
      end
      if (item_cmd == abht_pkg::CMD_ADD && add_code == abht_pkg::ST_STORED) begin
        res_cls  <= cls_code;
        res_slot <= blip_count[SLOT_W-1:0];
      end else begin
        res_cls  <= abht_pkg::CLS_NORMAL;
        res_slot <= '0;
      end
    end else if (state == abht_pkg::S_DIVX && div_done) begin
      res_px <= div_q;
    end else if (state == abht_pkg::S_DIVY && div_done) begin
      res_py <= div_q;
    end
  end

  abht_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Blip table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      blip_mem[blip_count[SLOT_W-1:0]] <= {res_px, div_q, item_tag};
    end
    if (rd_en) begin
      rd_data <= blip_mem[rd_idx];
    end
  end

  // Scan address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
      rd_idx     <= '0;
    end else begin
      scan_valid <= rd_en;
      if (state == abht_pkg::S_EVAL) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      scan_idx <= rd_idx;
    end
  end

  assign scan_ctl.clear = (state == abht_pkg::S_EVAL);
  assign scan_ctl.valid = scan_valid;

  abht_scan #(
    .SLOT_W  (SLOT_W),
    .HIT_PAD (HIT_PAD)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .idx       (scan_idx),
    .cx        (rd_data[MEM_W-1 -: abht_pkg::MAP_W]),
    .cy        (rd_data[abht_pkg::TAG_W +: abht_pkg::MAP_W]),
    .ctag      (rd_data[abht_pkg::TAG_W-1:0]),
    .tx        (item_tx),
    .ty        (item_ty),
    .found     (scan_found),
    .best_slot (scan_slot),
    .best_tag  (scan_tag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      add_status   <= res_status;
      pixel_x      <= res_px;
      pixel_y      <= res_py;
      colour_class <= res_cls;
      stored_slot  <= res_slot;
      blip_total   <= blip_count;
      if (item_cmd == abht_pkg::CMD_TOUCH && scan_found) begin
        hit_found <= 1'b1;
        hit_slot  <= scan_slot;
        hit_tag   <= scan_tag;
      end else begin
        hit_found <= 1'b0;
        hit_slot  <= '0;
        hit_tag   <= '0;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    blip_count <= CNT_W'(MAX_BLIPS))
    else $error("blip count beyond table size");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (blip_count < CNT_W'(MAX_BLIPS)))
    else $error("table write while full");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while another is in work");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == abht_pkg::S_DIVX || state == abht_pkg::S_DIVY))
    else $error("divider finished outside a divide state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (CNT_W'(rd_idx) < blip_count))
    else $error("scan read past stored blips");

endmodule

// ----- hdl/abht_div.sv -----
// Shift-subtract divider shared by both map axes, one quotient bit per cycle.
// Depends on abht_pkg for operand widths.
module abht_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [abht_pkg::PROD_W-1:0]   dividend,
  input  logic [abht_pkg::NUM_W-1:0]    divisor,
  output logic                          done,
  output logic [abht_pkg::MAP_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(abht_pkg::MAP_W + 1);

  logic                        busy;
  logic [STEP_W-1:0]           cnt;
  logic                        zero_div;
  logic [abht_pkg::NUM_W-1:0]  rem;
  logic [abht_pkg::NUM_W-1:0]  dsr;
  logic [abht_pkg::MAP_W-1:0]  q_sh;
  logic [abht_pkg::NUM_W:0]    trial;
  logic [abht_pkg::NUM_W+1:0]  diff;
  logic                        borrow;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial  = {rem, q_sh[abht_pkg::MAP_W-1]};
    diff   = {1'b0, trial} - {2'b00, dsr};
    borrow = diff[abht_pkg::NUM_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(abht_pkg::MAP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient is known to fit MAP_W bits, so the top part starts as remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[abht_pkg::PROD_W-1:abht_pkg::MAP_W];
      q_sh     <= dividend[abht_pkg::MAP_W-1:0];
      dsr      <= divisor;
      zero_div <= (divisor == '0);
    end else if (busy) begin
      if (borrow) begin
        rem <= trial[abht_pkg::NUM_W-1:0];
      end else begin
        rem <= diff[abht_pkg::NUM_W-1:0];
      end
      q_sh <= {q_sh[abht_pkg::MAP_W-2:0], ~borrow};
    end
  end

  // Zero range maps to offset zero
  assign quotient = zero_div ? '0 : q_sh;

endmodule

// ----- hdl/abht_scan.sv -----
// Hit-test unit: checks one stored blip per cycle against the touch point and
// keeps the nearest containing blip. Depends on abht_pkg.
module abht_scan #(
  parameter int SLOT_W  = 7,
  parameter int HIT_PAD = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  abht_pkg::scan_ctl_t                 ctl,
  input  logic [SLOT_W-1:0]                   idx,
  input  logic [abht_pkg::MAP_W-1:0]          cx,
  input  logic [abht_pkg::MAP_W-1:0]          cy,
  input  logic [abht_pkg::TAG_W-1:0]          ctag,
  input  logic signed [abht_pkg::TOUCH_W-1:0] tx,
  input  logic signed [abht_pkg::TOUCH_W-1:0] ty,
  output logic                                found,
  output logic [SLOT_W-1:0]                   best_slot,
  output logic [abht_pkg::TAG_W-1:0]          best_tag
);

  localparam int DX_W  = abht_pkg::TOUCH_W + 1;
  localparam int PAD_W = $clog2(HIT_PAD) + 2;
  localparam int SQ_W  = 2 * PAD_W;
  localparam int D2_W  = SQ_W + 1;
  localparam logic signed [DX_W-1:0] PAD_S = DX_W'(HIT_PAD);

  logic signed [DX_W-1:0]  dx, dy;
  logic signed [PAD_W-1:0] dxs, dys;
  logic signed [SQ_W-1:0]  sqx, sqy;
  logic [D2_W-1:0]         d2;
  logic [D2_W-1:0]         best_d2;
  logic                    in_box;
  logic                    take;

  // Offsets, box test and squared distance
  always_comb begin
    dx     = {tx[abht_pkg::TOUCH_W-1], tx} - {{(DX_W - abht_pkg::MAP_W){1'b0}}, cx};
    dy     = {ty[abht_pkg::TOUCH_W-1], ty} - {{(DX_W - abht_pkg::MAP_W){1'b0}}, cy};
    in_box = (dx >= -PAD_S) && (dx < PAD_S) && (dy >= -PAD_S) && (dy < PAD_S);
    dxs    = dx[PAD_W-1:0];
    dys    = dy[PAD_W-1:0];
    sqx    = dxs * dxs;
    sqy    = dys * dys;
    d2     = {1'b0, $unsigned(sqx)} + {1'b0, $unsigned(sqy)};
    take   = ctl.valid && in_box && (!found || (d2 < best_d2));
  end

  // Best-so-far; strict less-than keeps the earliest slot on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_d2   <= d2;
      best_slot <= idx;
      best_tag  <= ctag;
    end
  end

endmodule

// ----- sim/abht_checker.sv -----
// Scoreboard for the aircraft blip table: tracks config writes and requests, predicts each result.
// Depends on abht_pkg; instantiated beside the block by tb_aircraft_blip_table_hit_test.
module abht_checker (
  input  logic                                clk,
  input  logic                                rst,
  // configuration channel
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [abht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abht_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic signed [abht_pkg::LAT_W-1:0]   lat_pos,
  input  logic signed [abht_pkg::LON_W-1:0]   lon_pos,
  input  logic                                grounded,
  input  logic [abht_pkg::DIST_W-1:0]         dist_home_m,
  input  logic signed [abht_pkg::ALT_W-1:0]   baro_alt_m,
  input  logic [abht_pkg::TAG_W-1:0]          aircraft_tag,
  input  logic signed [abht_pkg::TOUCH_W-1:0] touch_x,
  input  logic signed [abht_pkg::TOUCH_W-1:0] touch_y,
  // result channel
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [1:0]                          add_status,
  input  logic [abht_pkg::MAP_W-1:0]          pixel_x,
  input  logic [abht_pkg::MAP_W-1:0]          pixel_y,
  input  logic [1:0]                          colour_class,
  input  logic [6:0]                          stored_slot,
  input  logic                                hit_found,
  input  logic [6:0]                          hit_slot,
  input  logic [abht_pkg::TAG_W-1:0]          hit_tag,
  input  logic [6:0]                          blip_total,
  // to the testbench top
  output int                                  fail_count,
  output int                                  answers_due
);

  localparam int TABLE_DEPTH = 80;
  localparam int PAD         = 12;

  typedef struct packed {
    logic [1:0]                 status;
    logic [abht_pkg::MAP_W-1:0] px;
    logic [abht_pkg::MAP_W-1:0] py;
    logic [1:0]                 cls;
    logic [6:0]                 slot;
    logic                       found;
    logic [6:0]                 hslot;
    logic [abht_pkg::TAG_W-1:0] htag;
    logic [6:0]                 total;
  } blip_answer_t;

  // register copies
  logic signed [abht_pkg::LAT_W-1:0] south_q, north_q;
  logic signed [abht_pkg::LON_W-1:0] west_q, east_q;
  logic [abht_pkg::MAP_W-1:0]        width_q, height_q;
  logic [abht_pkg::DIST_W-1:0]       near_q;
  logic [abht_pkg::LOWALT_W-1:0]     lowalt_q;

  // blip table copy
  logic [abht_pkg::MAP_W-1:0] x_tab [TABLE_DEPTH];
  logic [abht_pkg::MAP_W-1:0] y_tab [TABLE_DEPTH];
  logic [abht_pkg::TAG_W-1:0] tag_tab [TABLE_DEPTH];
  int                         fill_level;

  blip_answer_t answer_q [$];

  task automatic report(string msg);
    if (fail_count < 100)
      $display("[%0t] abht_checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  // truncating pixel offset; an empty or inverted span maps to zero
  function automatic longint axis_offset(longint num, longint span, longint size);
    if (span <= 0 || num < 0)
      return 0;
    return (num * size) / span;
  endfunction

  // result of the request on the ports, updating the table copy
  function automatic blip_answer_t compute_answer();
    blip_answer_t a;
    longint lat, lon, s, n, w, e, off;
    longint tx, ty, cx, cy, d2, best;
    int i;
    a = '0;
    best = 0;
    case (abht_pkg::cmd_t'(command))
      abht_pkg::CMD_CLEAR: fill_level = 0;
      abht_pkg::CMD_ADD: begin
        lat = longint'(lat_pos);
        lon = longint'(lon_pos);
        s = longint'(south_q);
        n = longint'(north_q);
        w = longint'(west_q);
        e = longint'(east_q);
        if (grounded) begin
          a.status = abht_pkg::ST_GROUNDED;
        end else if (!(lat >= s && lat <= n && lon >= w && lon <= e)) begin
          a.status = abht_pkg::ST_OUTSIDE;
        end else if (fill_level >= TABLE_DEPTH) begin
          a.status = abht_pkg::ST_FULL;
        end else begin
          a.status = abht_pkg::ST_STORED;
          off = axis_offset(lon - w, e - w, longint'(width_q));
          a.px = off[abht_pkg::MAP_W-1:0];
          off = axis_offset(n - lat, n - s, longint'(height_q));
          a.py = off[abht_pkg::MAP_W-1:0];
          if (longint'(dist_home_m) <= longint'(near_q))
            a.cls = abht_pkg::CLS_NEAR;
          else if (longint'(baro_alt_m) <= longint'(lowalt_q))
            a.cls = abht_pkg::CLS_LOW;
          else
            a.cls = abht_pkg::CLS_NORMAL;
          x_tab[fill_level] = a.px;
          y_tab[fill_level] = a.py;
          tag_tab[fill_level] = aircraft_tag;
          a.slot = fill_level[6:0];
          fill_level++;
        end
      end
      abht_pkg::CMD_TOUCH: begin
        tx = longint'(touch_x);
        ty = longint'(touch_y);
        // nearest containing blip; strict compare keeps the earliest slot on a tie
        for (i = 0; i < fill_level; i++) begin
          cx = longint'(x_tab[i]);
          cy = longint'(y_tab[i]);
          if (tx >= cx - PAD && tx < cx + PAD && ty >= cy - PAD && ty < cy + PAD) begin
            d2 = (tx - cx) * (tx - cx) + (ty - cy) * (ty - cy);
            if (!a.found || d2 < best) begin
              a.found = 1'b1;
              best = d2;
              a.hslot = i[6:0];
              a.htag = tag_tab[i];
            end
          end
        end
      end
      default: ;
    endcase
    a.total = fill_level[6:0];
    return a;
  endfunction

  always @(posedge clk) begin
    blip_answer_t want;
    if (rst) begin
      south_q = abht_pkg::LAT_SOUTH_RST;
      north_q = abht_pkg::LAT_NORTH_RST;
      west_q = abht_pkg::LON_WEST_RST;
      east_q = abht_pkg::LON_EAST_RST;
      width_q = abht_pkg::MAP_WIDTH_RST;
      height_q = abht_pkg::MAP_HEIGHT_RST;
      near_q = abht_pkg::NEAR_DIST_RST;
      lowalt_q = abht_pkg::LOW_ALT_RST;
      fill_level = 0;
      answer_q.delete();
      answers_due <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (abht_pkg::cfg_reg_t'(cfg_index))
          abht_pkg::REG_LAT_SOUTH:  south_q = cfg_data[abht_pkg::LAT_W-1:0];
          abht_pkg::REG_LAT_NORTH:  north_q = cfg_data[abht_pkg::LAT_W-1:0];
          abht_pkg::REG_LON_WEST:   west_q = cfg_data[abht_pkg::LON_W-1:0];
          abht_pkg::REG_LON_EAST:   east_q = cfg_data[abht_pkg::LON_W-1:0];
          abht_pkg::REG_MAP_WIDTH:  width_q = cfg_data[abht_pkg::MAP_W-1:0];
          abht_pkg::REG_MAP_HEIGHT: height_q = cfg_data[abht_pkg::MAP_W-1:0];
          abht_pkg::REG_NEAR_DIST:  near_q = cfg_data[abht_pkg::DIST_W-1:0];
          abht_pkg::REG_LOW_ALT:    lowalt_q = cfg_data[abht_pkg::LOWALT_W-1:0];
          default: ;
        endcase
      end
      // result against the oldest outstanding request
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report($sformatf("result with no request outstanding (blip_total %0d)",
                           blip_total));
        end else begin
          want = answer_q.pop_front();
          check_field("add_status", int'(add_status), int'(want.status));
          check_field("pixel_x", int'(pixel_x), int'(want.px));
          check_field("pixel_y", int'(pixel_y), int'(want.py));
          check_field("colour_class", int'(colour_class), int'(want.cls));
          check_field("stored_slot", int'(stored_slot), int'(want.slot));
          check_field("hit_found", int'(hit_found), int'(want.found));
          check_field("hit_slot", int'(hit_slot), int'(want.hslot));
          check_field("hit_tag", int'(hit_tag), int'(want.htag));
          check_field("blip_total", int'(blip_total), int'(want.total));
        end
      end
      // accepted request
      if (in_valid && in_ready)
        answer_q = {answer_q, compute_answer()};
      answers_due <= answer_q.size();
    end
  end

endmodule

// ----- sim/tb_aircraft_blip_table_hit_test.sv -----
// Testbench top for aircraft_blip_table_hit_test: clock, reset, stimulus and verdict.
// Depends on abht_pkg, the block itself and abht_checker, which does all result checking.
module tb_aircraft_blip_table_hit_test;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    abht_pkg::cmd_t cmd;
    int   lat;
    int   lon;
    bit   gnd;
    int   dist_m;
    int   alt;
    int   tag;
    int   tx;
    int   ty;
  } blip_req_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [abht_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [abht_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [1:0]                        command = '0;
  logic signed [abht_pkg::LAT_W-1:0] lat_pos = '0;
  logic signed [abht_pkg::LON_W-1:0] lon_pos = '0;
  logic                              grounded = 1'b0;
  logic [abht_pkg::DIST_W-1:0]       dist_home_m = '0;
  logic signed [abht_pkg::ALT_W-1:0] baro_alt_m = '0;
  logic [abht_pkg::TAG_W-1:0]        aircraft_tag = '0;
  logic signed [abht_pkg::TOUCH_W-1:0] touch_x = '0;
  logic signed [abht_pkg::TOUCH_W-1:0] touch_y = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [1:0]                        add_status;
  logic [abht_pkg::MAP_W-1:0]        pixel_x;
  logic [abht_pkg::MAP_W-1:0]        pixel_y;
  logic [1:0]                        colour_class;
  logic [6:0]                        stored_slot;
  logic                              hit_found;
  logic [6:0]                        hit_slot;
  logic [abht_pkg::TAG_W-1:0]        hit_tag;
  logic [6:0]                        blip_total;
  int                                fail_count;
  int                                answers_due;

  // idle percentage for both channels, changed per phase
  int idle_pct = 30;

  // register values as last written, used to aim stimulus
  int cur_south = -410000, cur_north = -330000;
  int cur_west = -635000, cur_east = -565000;
  int cur_w = 312, cur_h = 200;
  int cur_near = 10000, cur_lowalt = 3000;

  aircraft_blip_table_hit_test dut (.*);
  abht_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_aircraft_blip_table_hit_test: FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if (int'($urandom_range(99, 0)) >= idle_pct)
      return 0;
    if ($urandom_range(9, 0) == 0)
      return int'($urandom_range(60, 20));
    return int'($urandom_range(4, 1));
  endfunction

  function automatic int rand_between(int lo, int hi);
    if (hi <= lo)
      return lo;
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // coordinate mostly inside the box, some on or just past an edge, some anywhere
  function automatic int pick_coord(int lo, int hi, int flo, int fhi);
    int r;
    r = int'($urandom_range(99, 0));
    if (r < 70)
      return rand_between(lo, hi);
    if (r < 80)
      return $urandom_range(1, 0) ? lo : hi;
    if (r < 90)
      return clampi($urandom_range(1, 0) ? lo - 1 : hi + 1, flo, fhi);
    return rand_between(flo, fhi);
  endfunction

  // value around a threshold a quarter of the time
  function automatic int around(int thr, int lo, int hi);
    if ($urandom_range(3, 0) == 0)
      return clampi(thr + int'($urandom_range(2, 0)) - 1, lo, hi);
    return rand_between(lo, hi);
  endfunction

  // every field random over its range
  function automatic blip_req_t noise_req(abht_pkg::cmd_t c);
    blip_req_t r;
    r.cmd = c;
    r.lat = rand_between(-900000, 900000);
    r.lon = rand_between(-1800000, 1800000);
    r.gnd = 1'($urandom_range(1, 0));
    r.dist_m = int'($urandom_range(1048575, 0));
    r.alt = rand_between(-1000, 20000);
    r.tag = int'($urandom_range(255, 0));
    r.tx = rand_between(-2048, 2047);
    r.ty = rand_between(-2048, 2047);
    return r;
  endfunction

  function automatic blip_req_t add_req(int lat, int lon, bit gnd, int dist_m, int alt, int tag);
    blip_req_t r;
    r = noise_req(abht_pkg::CMD_ADD);
    r.lat = lat;
    r.lon = lon;
    r.gnd = gnd;
    r.dist_m = dist_m;
    r.alt = alt;
    r.tag = tag;
    return r;
  endfunction

  function automatic blip_req_t touch_req(int tx, int ty);
    blip_req_t r;
    r = noise_req(abht_pkg::CMD_TOUCH);
    r.tx = tx;
    r.ty = ty;
    return r;
  endfunction

  function automatic blip_req_t rand_add();
    return add_req(pick_coord(cur_south, cur_north, -900000, 900000),
                   pick_coord(cur_west, cur_east, -1800000, 1800000),
                   $urandom_range(99, 0) < 7,
                   around(cur_near, 0, 1048575),
                   around(cur_lowalt, -1000, 20000),
                   int'($urandom_range(255, 0)));
  endfunction

  // touches mostly land on or near the map area
  function automatic blip_req_t rand_touch();
    if ($urandom_range(9, 0) == 0)
      return noise_req(abht_pkg::CMD_TOUCH);
    return touch_req(rand_between(-14, cur_w + 13), rand_between(-14, cur_h + 13));
  endfunction

  // one request, after an optional gap
  task automatic send_req(blip_req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.cmd;
    lat_pos <= r.lat[abht_pkg::LAT_W-1:0];
    lon_pos <= r.lon[abht_pkg::LON_W-1:0];
    grounded <= r.gnd;
    dist_home_m <= r.dist_m[abht_pkg::DIST_W-1:0];
    baro_alt_m <= r.alt[abht_pkg::ALT_W-1:0];
    aircraft_tag <= r.tag[abht_pkg::TAG_W-1:0];
    touch_x <= r.tx[abht_pkg::TOUCH_W-1:0];
    touch_y <= r.ty[abht_pkg::TOUCH_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until every outstanding result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
  endtask

  // write all registers while the block is idle
  task automatic load_config(int s, int n, int w, int e, int mw, int mh, int nd, int la);
    int vals[8];
    int k;
    settle();
    vals = '{s, n, w, e, mw, mh, nd, la};
    for (k = 0; k < 8; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= abht_pkg::cfg_reg_t'(k);
      cfg_data <= vals[k][abht_pkg::CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_south = s;
    cur_north = n;
    cur_west = w;
    cur_east = e;
    cur_w = mw;
    cur_h = mh;
    cur_near = nd;
    cur_lowalt = la;
  endtask

  // random mix; a fill phase starts with a run of adds to reach a full table
  task automatic run_phase(int count, int idle, bit fill);
    blip_req_t r;
    int k, roll;
    idle_pct = idle;
    for (k = 0; k < count; k++) begin
      roll = int'($urandom_range(999, 0));
      if (fill && k < 140)
        r = rand_add();
      else if (roll < 5)
        r = noise_req(abht_pkg::CMD_NOP);
      else if (roll < 10)
        r = noise_req(abht_pkg::CMD_CLEAR);
      else if (roll < 640)
        r = rand_add();
      else
        r = rand_touch();
      if ($urandom_range(99, 0) == 0)
        settle();
      send_req(r);
    end
  endtask

  // receiver: ready in bursts, with random stalls
  initial begin
    int busy, g;
    forever begin
      out_ready <= 1'b1;
      busy = int'($urandom_range(12, 1));
      repeat (busy) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int s, n, w, e;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part on reset register values
    send_req(touch_req(0, 0));
    send_req(noise_req(abht_pkg::CMD_CLEAR));
    send_req(add_req(-410000, -635000, 1'b0, 0, 3000, 0));
    send_req(add_req(-330000, -565000, 1'b0, 1048575, -1000, 255));
    send_req(add_req(-370000, -600000, 1'b0, 10001, 3001, 90));
    send_req(add_req(-370000, -600000, 1'b0, 10000, 20000, 1));
    send_req(add_req(-370000, -600000, 1'b1, 0, 0, 2));
    send_req(add_req(-329999, -600000, 1'b0, 0, 0, 3));
    send_req(add_req(-370000, -635001, 1'b0, 0, 0, 4));
    send_req(add_req(900000, -1800000, 1'b0, 0, 0, 5));
    send_req(add_req(-900000, 1800000, 1'b0, 0, 0, 6));
    // two blips on one pixel: the earlier slot wins
    send_req(touch_req(156, 100));
    send_req(touch_req(0, 200));
    // edges of the half-open hit square
    send_req(touch_req(-12, 188));
    send_req(touch_req(12, 212));
    send_req(touch_req(2047, 2047));
    send_req(touch_req(-2048, -2048));
    send_req(noise_req(abht_pkg::CMD_NOP));
    send_req(noise_req(abht_pkg::CMD_CLEAR));
    send_req(touch_req(156, 100));
    // empty latitude span and inverted longitude span
    load_config(0, 0, 0, -1, 312, 200, 10000, 3000);
    send_req(add_req(0, 0, 1'b0, 0, 0, 11));
    load_config(0, 0, -1000, 1000, 1023, 1023, 0, 0);
    send_req(add_req(0, 1000, 1'b0, 0, -1000, 7));
    send_req(add_req(0, -1000, 1'b0, 1, 0, 9));
    send_req(touch_req(1023, 0));

    // random phases over several register settings
    load_config(-410000, -330000, -635000, -565000, 312, 200, 10000, 3000);
    run_phase(220, 30, 1'b0);
    load_config(-900000, 900000, -1800000, 1800000, 1023, 1023, 1048575, 20000);
    run_phase(200, 0, 1'b1);
    load_config(-1000, 1000, -2000, 2000, 1, 1, 0, 0);
    run_phase(220, 50, 1'b1);
    load_config(-50, 50, -80, 80, 8, 6, 500000, 10000);
    run_phase(220, 40, 1'b0);
    s = rand_between(-900000, 899999);
    n = rand_between(s + 1, 900000);
    w = rand_between(-1800000, 1799999);
    e = rand_between(w + 1, 1800000);
    load_config(s, n, w, e, rand_between(1, 1023), rand_between(1, 1023),
                rand_between(0, 1048575), rand_between(0, 20000));
    run_phase(220, 60, 1'b0);
    // empty longitude span
    load_config(-200000, 200000, 123456, 123456, 640, 480, 20000, 5000);
    run_phase(220, 30, 1'b0);

    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("tb_aircraft_blip_table_hit_test: PASS");
    else
      $display("tb_aircraft_blip_table_hit_test: FAIL");
    $finish;
  end

endmodule
